// ===== src/sogi_pkg.sv =====
package sogi_pkg;

  localparam int GAIN_WIDTH = 16;
  localparam int STEP_WIDTH = 24;
  localparam int GAIN_FRAC = 14;
  localparam int STEP_FRAC = 24;
  localparam int ACC_FRAC = 16;
  localparam int OUT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 24;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DAMPING_GAIN = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OMEGA_STEP = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RATE,
    ST_ALPHA,
    ST_BETA,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_KERR,
    PH_ALPHA,
    PH_BETA
  } phase_t;

endpackage

// ===== src/sogi_quadrature_generator.sv =====
// two-channel sogi quadrature signal generator (voltage and current)
// input stream: one beat carries a voltage and a current sample; s_tready is
//   high only while the block is idle, one beat is taken at a time
// output stream: one beat per input beat with the in-phase and quadrature
//   parts of both channels, saturated to 16 bits
// config channel: cfg_valid/cfg_index/cfg_data, always ready; index 0 is the
//   damping gain (q2.14), index 1 the angular step (q0.24), others ignored
// schedule: every product goes through one shared multiplier in two passes
//   (low and high half of the operand); a channel needs 3 products plus
//   4 add/saturate steps, the two channels are worked one after the other,
//   then the output register is loaded; m_tvalid rises together with
//   s_tready, so a new beat is taken only once the last result is loaded
// the output register parts both sides: the next beat is accepted while a
//   result still waits; if the receiver stalls longer the block holds its
//   finished result internally until the output register frees up
// reset (rst, synchronous): accumulators cleared, registers back to their
//   defaults, no result pending
module sogi_quadrature_generator
  import sogi_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // voltage_sample, current_sample
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // voltage_alpha, voltage_beta, current_alpha, current_beta
  output logic [4*OUT_WIDTH-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  localparam int PW = ACC_WIDTH + STEP_WIDTH;
  localparam int HL = ACC_WIDTH / 2;
  localparam int HH = ACC_WIDTH - HL;
  localparam int EW = ACC_WIDTH + 3;
  localparam int LSH = (SAMPLE_WIDTH - 1 <= ACC_FRAC) ? ACC_FRAC + 1 - SAMPLE_WIDTH : 0;
  localparam int RSH = (SAMPLE_WIDTH - 1 > ACC_FRAC) ? SAMPLE_WIDTH - 1 - ACC_FRAC : 0;
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< (ACC_WIDTH - 1)));
  localparam logic signed [ACC_WIDTH-1:0] OUT_HI = ACC_WIDTH'(32767);
  localparam logic signed [ACC_WIDTH-1:0] OUT_LO = ACC_WIDTH'(-32768);

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [EW-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > SAT_HI) r = SAT_HI[ACC_WIDTH-1:0];
    else if (v < SAT_LO) r = SAT_LO[ACC_WIDTH-1:0];
    else r = v[ACC_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [ACC_WIDTH-1:0] acc);
    logic signed [ACC_WIDTH-1:0] v;
    logic [OUT_WIDTH-1:0] r;
    v = acc >>> 1;
    if (v > OUT_HI) r = OUT_HI[OUT_WIDTH-1:0];
    else if (v < OUT_LO) r = OUT_LO[OUT_WIDTH-1:0];
    else r = v[OUT_WIDTH-1:0];
    return r;
  endfunction

  state_t state, state_next;
  phase_t phase, phase_next;
  logic ch, ch_next;

  logic [GAIN_WIDTH-1:0] damping_gain;
  logic [STEP_WIDTH-1:0] omega_step;

  logic signed [ACC_WIDTH-1:0] alpha [2];
  logic signed [ACC_WIDTH-1:0] beta [2];
  logic signed [ACC_WIDTH-1:0] samp [2];

  logic signed [ACC_WIDTH-1:0] opa;
  logic [STEP_WIDTH-1:0] opb;
  logic [HL+STEP_WIDTH-1:0] prod_lo;
  logic signed [PW-1:0] prod;

  logic signed [HH:0] mul_a;
  logic signed [HH+STEP_WIDTH+1:0] mul_p;
  logic signed [PW-1:0] prod_next;
  logic signed [EW-1:0] kerr;
  logic signed [EW-1:0] inc;
  logic signed [SAMPLE_WIDTH-1:0] v_raw, c_raw;
  logic s_accept;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  assign v_raw = s_tdata[SAMPLE_WIDTH-1:0];
  assign c_raw = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  // shared multiplier: unsigned low half of opa first, then its signed high half
  assign mul_a = (state == ST_MUL_HI) ? (HH+1)'($signed(opa[ACC_WIDTH-1:HL]))
                                      : (HH+1)'(opa[HL-1:0]);
  assign mul_p = mul_a * $signed({1'b0, opb});
  assign prod_next = (PW'(mul_p) <<< HL) + $signed(PW'(prod_lo));
  assign kerr = EW'(prod >>> GAIN_FRAC);
  assign inc = EW'(prod >>> STEP_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_KERR;
      ch <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      ch <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    ch_next = ch;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = ST_ERR;
          ch_next = 1'b0;
        end
      end
      ST_ERR: begin
        state_next = ST_MUL_LO;
        phase_next = PH_KERR;
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: begin
        unique case (phase)
          PH_KERR: state_next = ST_RATE;
          PH_ALPHA: state_next = ST_ALPHA;
          PH_BETA: state_next = ST_BETA;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RATE: begin
        state_next = ST_MUL_LO;
        phase_next = PH_ALPHA;
      end
      ST_ALPHA: begin
        state_next = ST_MUL_LO;
        phase_next = PH_BETA;
      end
      ST_BETA: begin
        if (ch) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_ERR;
          ch_next = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_gain <= GAIN_WIDTH'(23170);
      omega_step <= STEP_WIDTH'(263533);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DAMPING_GAIN: damping_gain <= cfg_data[GAIN_WIDTH-1:0];
        REG_OMEGA_STEP: omega_step <= cfg_data[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha[0] <= '0;
      alpha[1] <= '0;
      beta[0] <= '0;
      beta[1] <= '0;
    end else begin
      if (state == ST_ALPHA) alpha[ch] <= sat_acc(EW'(alpha[ch]) + inc);
      if (state == ST_BETA) beta[ch] <= sat_acc(EW'(beta[ch]) + inc);
    end
  end

  // operands and products
  always_ff @(posedge clk) begin
    if (s_accept) begin
      samp[0] <= (ACC_WIDTH'(v_raw) <<< LSH) >>> RSH;
      samp[1] <= (ACC_WIDTH'(c_raw) <<< LSH) >>> RSH;
    end
    unique case (state)
      ST_ERR: begin
        opa <= sat_acc(EW'(samp[ch]) - EW'(alpha[ch]));
        opb <= STEP_WIDTH'(damping_gain);
      end
      ST_MUL_LO: prod_lo <= mul_p[HL+STEP_WIDTH-1:0];
      ST_MUL_HI: prod <= prod_next;
      ST_RATE: begin
        opa <= sat_acc(kerr - EW'(beta[ch]));
        opb <= omega_step;
      end
      ST_ALPHA: opa <= sat_acc(EW'(alpha[ch]) + inc);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {to_out(beta[1]), to_out(alpha[1]), to_out(beta[0]), to_out(alpha[0])};
    end
  end

`ifndef SYNTHESIS
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input beat accepted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && m_tvalid && !m_tready |=> state == ST_FINISH)
    else $error("pending result overwritten");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result shown without finished computation");
`endif

endmodule
